/* hdl/tilt_heading_range_of_motion_top_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef TILT_HEADING_RANGE_OF_MOTION_TOP_MACROS_SVH
`define TILT_HEADING_RANGE_OF_MOTION_TOP_MACROS_SVH

// Concurrent implication check, consequent in the same cycle as the antecedent.
`define THRM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check in the cycle after the antecedent.
`define THRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/thrm_pkg.sv */
// ----------------------------------------------------------------------------
// thrm_pkg
// Shared constants, codes and the arctangent table for the tilt/heading block.
// ----------------------------------------------------------------------------
package thrm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ATAN_TAB_LEN        = 24;
    localparam int ACC_FRAC            = 16;
    localparam int CORD_W              = 28;
    localparam int Z_W                 = 26;
    localparam int ROOT_W              = 24;
    localparam int RAD_W               = 48;

    localparam logic signed [14:0] DECL_RESET = -15'sd1320;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    // unused code, handled as no command
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // round(atan(2^-i) * 65536), degrees
    function automatic logic [23:0] atan_entry(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            5'd20: v = 24'd4;
            5'd21: v = 24'd2;
            5'd22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/thrm_isqrt.sv */
// ----------------------------------------------------------------------------
// thrm_isqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module thrm_isqrt
    import thrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+2:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic              r_done;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic              take;

    assign rem_sh = {r_rem[ROOT_W:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/thrm_cordic.sv */
// ----------------------------------------------------------------------------
// thrm_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module thrm_cordic
    import thrm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int AW              = ANGLE_FRAC_BITS_DEF + 10
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [CORD_W-1:0] i_y,
    input  logic signed [CORD_W-1:0] i_x,
    output logic                     o_done,
    output logic signed [AW-1:0]     o_angle
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
    localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] QUARTER = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] HALF    = Z_W'(1) <<< (SH - 1);

    logic                     r_busy;
    logic                     r_done;
    logic                     r_zero;
    logic [4:0]               r_i;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [Z_W-1:0]    r_z;

    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [Z_W-1:0]    tab;
    logic signed [Z_W-1:0]    zr;

    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign tab = Z_W'(atan_entry(r_i));
    assign zr  = r_z + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                // left half plane: quarter turn first
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        r_x <= i_y;
                        r_y <= -i_x;
                        r_z <= QUARTER;
                    end else begin
                        r_x <= -i_y;
                        r_y <= i_x;
                        r_z <= -QUARTER;
                    end
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + tab;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - tab;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : AW'(zr >>> SH);

endmodule

/* hdl/tilt_heading_range_of_motion_top.sv */
// ----------------------------------------------------------------------------
// tilt_heading_range_of_motion_top
// Pitch, roll and heading from raw IMU samples, with range-of-motion report.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one sample and a command (mode).
// Output channel o_valid/i_ready returns one result per input transaction:
// pitch, roll, heading (1/2^ANGLE_FRAC_BITS degree) plus the recording
// status and, on finish, the range/peak/offset report.
// Config channel i_cfg_valid/o_cfg_ready writes the declination; always ready.
// One item is handled at a time: o_ready is high only while the sequencer is
// idle. The sequencer squares the y and z accelerations (one shared multiplier),
// takes the square root (one bit a cycle), runs three atan2 passes on one
// shared CORDIC, wraps the heading and registers the result. The next
// sample is taken the cycle after the result is registered. If the receiver
// stalls, the result waits in the output register and the next result waits
// in the last sequencer step.
// Synchronous reset clears the recording state and sets declination to -1320.
// ----------------------------------------------------------------------------
`include "tilt_heading_range_of_motion_top_macros.svh"

module tilt_heading_range_of_motion_top
    import thrm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_acc_x,
    input  logic signed [15:0] i_acc_y,
    input  logic signed [15:0] i_acc_z,
    input  logic signed [15:0] i_mag_x,
    input  logic signed [15:0] i_mag_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [14:0] i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [13:0] o_pitch,
    output logic signed [14:0] o_roll,
    output logic [14:0]        o_heading,
    output logic               o_recording,
    output logic               o_report_valid,
    output logic               o_no_data,
    output logic [13:0]        o_range_total,
    output logic [13:0]        o_peak_incline,
    output logic [13:0]        o_final_offset
);

    localparam int AW = ANGLE_FRAC_BITS + 10;
    localparam int HW = ((AW > 16) ? AW : 16) + 2;
    localparam logic signed [HW-1:0] FULL = HW'(360) <<< ANGLE_FRAC_BITS;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQA  = 7'b0000010,
        ST_SQB  = 7'b0000100,
        ST_SQRT = 7'b0001000,
        ST_CORD = 7'b0010000,
        ST_WRAP = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    logic [1:0]          r_pass;
    logic [1:0]          r_mode;
    logic signed [15:0]  r_ax, r_ay, r_az, r_mx, r_my;
    logic signed [14:0]  r_decl;
    logic [31:0]         r_sq;
    logic signed [AW-1:0] r_pitch, r_roll;
    logic signed [HW-1:0] r_h;

    logic                r_rec;
    logic                r_has;
    logic signed [AW-1:0] r_start, r_max, r_min;

    logic                r_out_valid;
    logic signed [13:0]  r_o_pitch;
    logic signed [14:0]  r_o_roll;
    logic [14:0]         r_o_head;
    logic                r_o_rec, r_o_rv, r_o_nd;
    logic [13:0]         r_o_rt, r_o_pk, r_o_fo;

    // shared multiplier
    logic signed [15:0]  mul_a;
    logic signed [31:0]  mul_p;
    assign mul_a = (r_state == ST_SQA) ? r_ay : r_az;
    assign mul_p = mul_a * mul_a;

    logic                sq_done;
    logic [ROOT_W-1:0]   root;
    thrm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_SQB),
        .i_radicand ({r_sq[31:0] + 32'(unsigned'(mul_p)), 16'd0}),
        .o_done     (sq_done),
        .o_root     (root)
    );

    // operand select for the next CORDIC pass
    logic [1:0]               sel;
    logic                     c_start;
    logic signed [CORD_W-1:0] c_y, c_x;
    logic                     c_done;
    logic signed [AW-1:0]     c_ang;
    logic signed [16:0]       nax;

    assign nax     = -{r_ax[15], r_ax};
    assign c_start = ((r_state == ST_SQRT) && sq_done) ||
                     ((r_state == ST_CORD) && c_done && (r_pass != 2'd2));
    assign sel     = (r_state == ST_SQRT) ? 2'd0 : r_pass + 2'd1;

    always_comb begin
        case (sel)
            2'd0: begin
                c_y = CORD_W'(nax) <<< 8;
                c_x = CORD_W'({1'b0, root});
            end
            2'd1: begin
                c_y = CORD_W'(r_ay) <<< 8;
                c_x = CORD_W'(r_az) <<< 8;
            end
            default: begin
                c_y = CORD_W'(r_my) <<< 8;
                c_x = CORD_W'(r_mx) <<< 8;
            end
        endcase
    end

    thrm_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS),
        .AW              (AW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_y     (c_y),
        .i_x     (c_x),
        .o_done  (c_done),
        .o_angle (c_ang)
    );

    // range-of-motion update for the finished item
    logic                 n_rec, n_has, n_rv, n_nd;
    logic signed [AW-1:0] n_start, n_max, n_min;
    logic signed [AW:0]   d_rt, d_pk, d_fo;
    logic [13:0]          n_rt, n_pk, n_fo;

    always_comb begin
        n_rec   = r_rec;
        n_has   = r_has;
        n_start = r_start;
        n_max   = r_max;
        n_min   = r_min;
        n_rv    = 1'b0;
        n_nd    = 1'b0;
        n_rt    = '0;
        n_pk    = '0;
        n_fo    = '0;
        d_rt    = (AW+1)'(r_max) - (AW+1)'(r_min);
        d_pk    = (AW+1)'(r_max) - (AW+1)'(r_start);
        d_fo    = (AW+1)'(r_pitch) - (AW+1)'(r_start);
        if (d_pk < 0) d_pk = -d_pk;
        if (d_fo < 0) d_fo = -d_fo;
        if (r_mode == MODE_START) begin
            n_start = r_pitch;
            n_rec   = 1'b1;
            n_has   = 1'b1;
            n_max   = r_pitch;
            n_min   = r_pitch;
        end else if (r_mode == MODE_FINISH) begin
            n_rec = 1'b0;
            n_rv  = 1'b1;
            if (!r_has) begin
                n_nd = 1'b1;
            end else begin
                n_rt = 14'(d_rt);
                n_pk = 14'(d_pk);
                n_fo = 14'(d_fo);
            end
            n_has = 1'b0;
        end
        if (n_rec && (r_mode != MODE_START)) begin
            if (r_pitch > n_max) n_max = r_pitch;
            if (r_pitch < n_min) n_min = r_pitch;
        end
    end

    logic fire_out;
    assign fire_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= '0;
            r_decl      <= DECL_RESET;
            r_rec       <= 1'b0;
            r_has       <= 1'b0;
            r_start     <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_decl <= i_cfg_data;
            if (r_out_valid && i_ready && !fire_out) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_mode  <= i_mode;
                        r_ax    <= i_acc_x;
                        r_ay    <= i_acc_y;
                        r_az    <= i_acc_z;
                        r_mx    <= i_mag_x;
                        r_my    <= i_mag_y;
                        r_state <= ST_SQA;
                    end
                end
                ST_SQA: begin
                    r_sq    <= unsigned'(mul_p);
                    r_state <= ST_SQB;
                end
                ST_SQB: r_state <= ST_SQRT;
                ST_SQRT: begin
                    if (sq_done) begin
                        r_pass  <= 2'd0;
                        r_state <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (c_done) begin
                        r_pass <= r_pass + 2'd1;
                        case (r_pass)
                            2'd0: r_pitch <= c_ang;
                            2'd1: r_roll  <= c_ang;
                            default: begin
                                r_h     <= HW'(c_ang) + HW'(r_decl);
                                r_state <= ST_WRAP;
                            end
                        endcase
                    end
                end
                ST_WRAP: begin
                    if (r_h < 0) r_h <= r_h + FULL;
                    else if (r_h >= FULL) r_h <= r_h - FULL;
                    else r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (fire_out) begin
                        r_rec       <= n_rec;
                        r_has       <= n_has;
                        r_start     <= n_start;
                        r_max       <= n_max;
                        r_min       <= n_min;
                        r_out_valid <= 1'b1;
                        r_o_pitch   <= 14'(r_pitch);
                        r_o_roll    <= 15'(r_roll);
                        r_o_head    <= 15'(r_h);
                        r_o_rec     <= n_rec;
                        r_o_rv      <= n_rv;
                        r_o_nd      <= n_nd;
                        r_o_rt      <= n_rt;
                        r_o_pk      <= n_pk;
                        r_o_fo      <= n_fo;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_pitch        = r_o_pitch;
    assign o_roll         = r_o_roll;
    assign o_heading      = r_o_head;
    assign o_recording    = r_o_rec;
    assign o_report_valid = r_o_rv;
    assign o_no_data      = r_o_nd;
    assign o_range_total  = r_o_rt;
    assign o_peak_incline = r_o_pk;
    assign o_final_offset = r_o_fo;

    `THRM_ASSERT_IMPL(a_report_stops, o_valid && o_report_valid, !o_recording,
        "report issued while still recording")
    `THRM_ASSERT_IMPL(a_nodata_zero, o_valid && o_no_data,
        (o_range_total == 14'd0) && (o_final_offset == 14'd0) && o_report_valid,
        "no_data report with nonzero fields")
    `THRM_ASSERT_IMPL(a_wrap_done, fire_out, (r_h >= 0) && (r_h < FULL),
        "heading left the wrap step out of range")
    `THRM_ASSERT_NEXT(a_accept_busy, i_valid && o_ready, !o_ready,
        "sequencer did not leave idle after accepting a sample")

endmodule
